### hdl/mcu_host_mailbox_bus_bridge_top_assert.svh
// Assertion macros for the bridge RTL, used by mhb_core.
`ifndef MCU_HOST_MAILBOX_BUS_BRIDGE_TOP_ASSERT_SVH
`define MCU_HOST_MAILBOX_BUS_BRIDGE_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is active.
`define MHB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same, checking the consequent in the cycle after the antecedent.
`define MHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mhb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhb_pkg;

  typedef enum logic [2:0] {
    REQ_HOST_RD   = 3'd0,
    REQ_HOST_WR   = 3'd1,
    REQ_HOST_STAT = 3'd2,
    REQ_PA_RD     = 3'd3,
    REQ_PA_WR     = 3'd4,
    REQ_PB_WR     = 3'd5,
    REQ_PC_RD     = 3'd6,
    REQ_MEM_RET   = 3'd7
  } req_e;

  // Port B strobe bit positions, active low
  localparam int unsigned PB_TAKE_HOST = 1;
  localparam int unsigned PB_GIVE_HOST = 2;
  localparam int unsigned PB_MEM_WR    = 4;
  localparam int unsigned PB_MEM_RD    = 5;
  localparam int unsigned PB_ADDR_LO   = 6;
  localparam int unsigned PB_ADDR_HI   = 7;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        mem_read;
    logic [15:0] read_address;
    logic        irq_pulse;
    logic        irq_line;
  } res_t;

endpackage

`default_nettype wire

### hdl/mhb_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "mcu_host_mailbox_bus_bridge_top_assert.svh"

module mhb_core import mhb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire req_e       req_type_i,
  input  wire logic [7:0] data_i,
  output res_t            res_o
);

  logic [7:0]  h2m_q, h2m_d;
  logic [7:0]  m2h_q, m2h_d;
  logic        ready_q, ready_d;
  logic        accept_q, accept_d;
  logic [7:0]  pin_q, pin_d;
  logic [7:0]  pout_q, pout_d;
  logic [15:0] addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h2m_q    <= 8'h00;
      m2h_q    <= 8'h00;
      ready_q  <= 1'b0;
      accept_q <= 1'b1;
      pin_q    <= 8'h00;
      pout_q   <= 8'h00;
      addr_q   <= 16'h0000;
    end else if (fire_i) begin
      h2m_q    <= h2m_d;
      m2h_q    <= m2h_d;
      ready_q  <= ready_d;
      accept_q <= accept_d;
      pin_q    <= pin_d;
      pout_q   <= pout_d;
      addr_q   <= addr_d;
    end
  end

  always_comb begin
    h2m_d    = h2m_q;
    m2h_d    = m2h_q;
    ready_d  = ready_q;
    accept_d = accept_q;
    pin_d    = pin_q;
    pout_d   = pout_q;
    addr_d   = addr_q;
    res_o    = '0;

    unique case (req_type_i)
      REQ_HOST_RD: begin
        accept_d        = 1'b1;
        res_o.read_data = m2h_q;
      end
      REQ_HOST_WR: begin
        res_o.irq_pulse = !ready_q;
        ready_d         = 1'b1;
        h2m_d           = data_i;
      end
      REQ_HOST_STAT: res_o.read_data = ~{6'b0, accept_q, ready_q};
      REQ_PA_RD:     res_o.read_data = pin_q;
      REQ_PA_WR:     pout_d = data_i;
      REQ_PB_WR: begin
        if (!data_i[PB_TAKE_HOST]) begin
          ready_d = 1'b0;
          pin_d   = h2m_q;
        end
        if (!data_i[PB_GIVE_HOST]) begin
          accept_d = 1'b0;
          m2h_d    = pout_q;
        end
        // write first, then bump only the low byte
        if (!data_i[PB_MEM_WR]) begin
          res_o.mem_write     = 1'b1;
          res_o.write_address = addr_q;
          res_o.write_data    = pout_q;
          addr_d[7:0]         = addr_q[7:0] + 8'd1;
        end
        // read sees the post-increment address
        if (!data_i[PB_MEM_RD]) begin
          res_o.mem_read     = 1'b1;
          res_o.read_address = addr_d;
        end
        if (!data_i[PB_ADDR_LO]) addr_d[7:0]  = pout_q;
        if (!data_i[PB_ADDR_HI]) addr_d[15:8] = pout_q;
      end
      REQ_PC_RD:     res_o.read_data = {6'b0, accept_q, ready_q};
      REQ_MEM_RET:   pin_d = data_i;
    endcase

    res_o.irq_line = !ready_d;
  end

  `MHB_ASSERT(a_pulse_needs_clear, !res_o.irq_pulse || (!ready_q && req_type_i == REQ_HOST_WR),
              "irq pulse without a host write to a clear flag")
  `MHB_ASSERT_NEXT(a_host_wr_sets_ready, fire_i && req_type_i == REQ_HOST_WR, ready_q,
                   "host write did not set ready flag")
  `MHB_ASSERT_NEXT(a_wr_bumps_low,
                   fire_i && res_o.mem_write && data_i[PB_ADDR_LO] && data_i[PB_ADDR_HI],
                   addr_q[7:0] == $past(addr_q[7:0]) + 8'd1 &&
                   addr_q[15:8] == $past(addr_q[15:8]),
                   "memory write did not bump low address byte")

endmodule

`default_nettype wire

### hdl/mcu_host_mailbox_bus_bridge_top.sv
// Host / microcontroller mailbox and bus-master bridge.
// Request channel: in_valid_i / in_ready_o with req_type_i and data_i. One
// request is one access from the host or the controller (host data read or
// write, status read, port A/B/C access, or returned memory read data).
// Response channel: out_valid_o / out_ready_i; every request yields exactly
// one response carrying read data, any issued bus write or read, the irq
// pulse and the current controller irq level.
// Path: an accepted request waits in the request register and is processed
// into the response register, from which out_valid_o offers its response.
// Throughput: one request per cycle while out_ready_i stays high. The limit is the single
// update of the mailbox state per cycle.
// Stall: while the response register is full and out_ready_i is low, the
// request register holds one more request; after that in_ready_o drops.
// Nothing is lost or reordered.
// Reset (rst_ni low, async): both pipeline registers empty, latches and
// address cleared, host accept flag set and host ready flag clear, so the
// first response shows irq_line high unless it is a host data write.
`timescale 1ns / 1ps
`default_nettype none

module mcu_host_mailbox_bus_bridge_top import mhb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             mem_write_o,
  output logic [15:0]      write_address_o,
  output logic [7:0]       write_data_o,
  output logic             mem_read_o,
  output logic [15:0]      read_address_o,
  output logic             irq_pulse_o,
  output logic             irq_line_o
);

  // request register
  logic       in_valid_q;
  req_e       type_q;
  logic [7:0] data_q;

  // response register
  logic out_valid_q;
  res_t res_q;
  res_t res;

  logic fire;  // request in the request register is processed this cycle

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      type_q      <= REQ_HOST_RD;
      data_q      <= 8'h00;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (in_ready_o && in_valid_i) begin
        type_q <= req_e'(req_type_i);
        data_q <= data_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res;
  end

  mhb_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (type_q),
    .data_i     (data_q),
    .res_o      (res)
  );

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_data;
  assign mem_write_o     = res_q.mem_write;
  assign write_address_o = res_q.write_address;
  assign write_data_o    = res_q.write_data;
  assign mem_read_o      = res_q.mem_read;
  assign read_address_o  = res_q.read_address;
  assign irq_pulse_o     = res_q.irq_pulse;
  assign irq_line_o      = res_q.irq_line;

endmodule

`default_nettype wire
